### sv/pli_pkg.sv
// Package: payload types and constants for the piecewise linear interpolator.
package pli_pkg;

	localparam int unsigned MaxKnotsDefault = 256;
	localparam int unsigned FracBitsDefault = 16;
	localparam int unsigned SizeW = 9;
	localparam int unsigned IdxW = 8;
	localparam logic ActLoad = 1'b0;
	localparam logic ActQuery = 1'b1;

	typedef struct packed {
		logic              action;
		logic [IdxW-1:0]   entry_index;
		logic signed [31:0] knot_x;
		logic signed [31:0] knot_y;
		logic signed [31:0] query_t;
	} req_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic [SizeW-1:0]   knot_index;
	} rsp_t;

endpackage

### sv/pli_ram.sv
// Generic single-port RAM with registered read.
module pli_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### sv/pli_divider.sv
// Restoring divider: fraction = floor((num << FracBits) / den), one bit per cycle.
module pli_divider #(
	parameter int unsigned FracBits = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [32:0]         num,
	input  logic [32:0]         den,
	output logic                done,
	output logic [FracBits-1:0] quo
);
	localparam int unsigned CntW = $clog2(FracBits + 1);

	logic [33:0]         rem_q;
	logic [32:0]         den_q;
	logic [FracBits-1:0] quo_q;
	logic [CntW-1:0]     cnt_q;
	logic                run_q;
	logic [34:0]         shl;
	logic                fits;

	assign shl  = {rem_q, 1'b0};
	assign fits = shl >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= CntW'(FracBits);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? 34'(shl - {2'b00, den_q}) : shl[33:0];
			quo_q <= {quo_q[FracBits-2:0], fits};
		end
	end

	assign done = run_q && (cnt_q == CntW'(1));
	assign quo  = {quo_q[FracBits-2:0], fits};
endmodule

### sv/piecewise_linear_interpolator.sv
// Top level: knot table in RAM, binary search, serial fraction divide, blend.
//  channel | signals                        | handshake
//  request | start, busy, request           | accepted when start && !busy
//  result  | result_valid, result           | one-cycle strobe, no stall
//  config  | cfg_we, cfg_wdata              | written when cfg_we
// A load holds busy while the knot is written. A query outside the table holds busy
// only for reading the end knots; inside it, also for S search steps (at most 9 at 256
// knots, each probing one knot), the serial divide at one fraction bit per cycle, and the blend.
// result_valid is high in the cycle in which busy falls.
// Reset leaves the table undefined; table_size returns to 1. The receiver cannot stall.
module piecewise_linear_interpolator #(
	parameter int unsigned MAX_KNOTS = pli_pkg::MaxKnotsDefault,
	parameter int unsigned FRAC_BITS = pli_pkg::FracBitsDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  pli_pkg::req_t             request,
	output logic                      result_valid,
	output pli_pkg::rsp_t             result,
	input  logic                      cfg_we,
	input  logic [pli_pkg::SizeW-1:0] cfg_wdata
);
	import pli_pkg::*;

	localparam int unsigned AW = $clog2(MAX_KNOTS);
	localparam int unsigned MW = AW + 2;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_WR    = 12'b000000000010,
		S_RD0   = 12'b000000000100,
		S_RDL   = 12'b000000001000,
		S_CHK   = 12'b000000010000,
		S_SRD   = 12'b000000100000,
		S_SCMP  = 12'b000001000000,
		S_RDX0  = 12'b000010000000,
		S_RDX1  = 12'b000100000000,
		S_DIV   = 12'b001000000000,
		S_MUL   = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t              st_q;
	logic [SizeW-1:0]    size_q;
	req_t                req_q;
	logic [MW-1:0]       m_q, lo_q, hi_q;
	logic [AW-1:0]       addr;
	logic                we;
	logic [31:0]         xr, yr;
	logic signed [31:0]  x0_q, y0_q, x1_q, y1_q, v_q;
	logic [SizeW-1:0]    idx_q;
	logic                div_go, div_done;
	logic                div_on_q;
	logic [FRAC_BITS-1:0] frac, a_q;
	logic signed [32:0]  num_w, den_w;
	logic signed [FRAC_BITS+1:0] a_s, b_s;
	logic signed [FRAC_BITS+33:0] p1_s2, p0_s2;
	logic signed [FRAC_BITS+34:0] sum;
	logic [MW-1:0]       mid;
	logic                pmul_q;

	pli_ram #(.Width(32), .Depth(MAX_KNOTS)) u_xram (
		.clk(clk), .we(we), .addr(addr), .wdata(req_q.knot_x), .rdata(xr));
	pli_ram #(.Width(32), .Depth(MAX_KNOTS)) u_yram (
		.clk(clk), .we(we), .addr(addr), .wdata(req_q.knot_y), .rdata(yr));

	assign we  = (st_q == S_WR);
	assign mid = MW'((lo_q + hi_q) >> 1);
	assign num_w = 33'(signed'(req_q.query_t)) - 33'(x0_q);
	assign den_w = 33'(x1_q) - 33'(x0_q);

	always_comb begin
		unique case (st_q)
			S_WR:    addr = AW'(req_q.entry_index);
			S_RD0:   addr = '0;
			S_RDL:   addr = AW'(m_q - 1'b1);
			S_SRD:   addr = mid[AW-1:0];
			S_RDX0:  addr = AW'(hi_q - 1'b1);
			S_RDX1:  addr = hi_q[AW-1:0];
			default: addr = '0;
		endcase
	end

	pli_divider #(.FracBits(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(num_w), .den(den_w), .done(div_done), .quo(frac));

	assign div_go = (st_q == S_DIV) && !pmul_q && !div_on_q;

	assign a_s = {2'b00, a_q};
	assign b_s = (FRAC_BITS+2)'(1 << FRAC_BITS) - a_s;
	assign sum = (FRAC_BITS+35)'(p1_s2) + (FRAC_BITS+35)'(p0_s2);

	always_ff @(posedge clk) begin
		p1_s2 <= a_s * y1_q;
		p0_s2 <= b_s * y0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			size_q <= SizeW'(1);
			result_valid <= 1'b0;
			pmul_q <= 1'b0;
			div_on_q <= 1'b0;
		end else begin
			result_valid <= (st_q == S_OUT);
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			unique case (st_q)
				S_IDLE: if (start) begin
					if (request.action == ActLoad) begin
						st_q <= (32'(request.entry_index) < MAX_KNOTS) ? S_WR : S_IDLE;
					end else begin
						st_q <= S_RD0;
					end
				end
				S_WR:   st_q <= S_IDLE;
				S_RD0:  st_q <= S_RDL;
				S_RDL:  st_q <= S_CHK;
				S_CHK: begin
					if (signed'(req_q.query_t) <= x0_q ||
							signed'(req_q.query_t) >= signed'(xr))
						st_q <= S_OUT;
					else if (hi_q - lo_q > MW'(1)) st_q <= S_SRD;
					else st_q <= S_RDX0;
				end
				S_SRD:  st_q <= S_SCMP;
				S_SCMP: begin
					if (signed'(xr) > req_q.query_t)
						st_q <= (mid - lo_q > MW'(1)) ? S_SRD : S_RDX0;
					else
						st_q <= (hi_q - mid > MW'(1)) ? S_SRD : S_RDX0;
				end
				S_RDX0: st_q <= S_RDX1;
				S_RDX1: begin
					st_q <= S_DIV;
					pmul_q <= 1'b1;
				end
				S_DIV: begin
					pmul_q <= 1'b0;
					if (div_done) begin
						div_on_q <= 1'b0;
						st_q <= S_MUL;
					end else if (div_go) begin
						div_on_q <= 1'b1;
					end
				end
				S_MUL: begin
					pmul_q <= ~pmul_q;
					if (pmul_q) st_q <= S_OUT;
				end
				S_OUT:  st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (start) begin
				req_q <= request;
				if (size_q == '0) m_q <= MW'(1);
				else if (32'(size_q) > MAX_KNOTS) m_q <= MW'(MAX_KNOTS);
				else m_q <= MW'(size_q);
			end
			S_RDL: begin
				x0_q <= xr; y0_q <= yr;
				lo_q <= '1;
				hi_q <= m_q;
			end
			S_CHK: begin
				if (signed'(req_q.query_t) <= x0_q) begin
					v_q <= y0_q; idx_q <= '0;
				end else begin
					v_q <= yr; idx_q <= SizeW'(m_q);
				end
			end
			S_SCMP: begin
				if (signed'(xr) > req_q.query_t) hi_q <= mid;
				else lo_q <= mid;
			end
			S_RDX1: begin x0_q <= xr; y0_q <= yr; end
			S_DIV: begin
				if (pmul_q) begin
					x1_q <= xr; y1_q <= yr;
				end
				if (div_done) a_q <= (den_w == '0 || num_w >= den_w) ? '0 : frac;
			end
			S_MUL: if (pmul_q) begin
				v_q <= 32'(sum >>> FRAC_BITS);
				idx_q <= SizeW'(hi_q);
			end
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign result.interp_value = v_q;
	assign result.knot_index   = idx_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(st_q) == S_OUT) else $error("result without finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> $past(req_q.action) == ActLoad || $past(st_q) == S_IDLE)
		else $error("write outside load");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SCMP |-> hi_q > lo_q || lo_q == '1) else $error("search bounds");
endmodule

### sim/piecewise_linear_interpolator_tb.sv
// Self-checking testbench: piecewise linear interpolator, directed table then random phases.
`timescale 1ns / 100ps

module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam int Knots = MaxKnotsDefault;
	localparam int Frac = FracBitsDefault;
	localparam int Settle = 60;
	localparam logic signed [31:0] Smin = 32'sh8000_0000;
	localparam logic signed [31:0] Smax = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Three = 32'sh0003_0000;

	typedef struct packed {
		logic             is_cfg;
		logic [SizeW-1:0] size_val;
		req_t             req;
		logic             typed;
		rsp_t             exp;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             request;
	logic             result_valid;
	rsp_t             result;
	logic             cfg_we;
	logic [SizeW-1:0] cfg_wdata;

	logic signed [31:0] knot_xs [Knots];
	logic signed [31:0] knot_ys [Knots];
	logic [SizeW-1:0]   size_reg;
	rsp_t               pending_rsp [$];
	int                 errors;
	int                 burst_left;
	row_t               dir_rows [17];

	piecewise_linear_interpolator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	function automatic rsp_t interp_predict(logic signed [31:0] t);
		rsp_t   r;
		int     m;
		int     lo;
		int     hi;
		int     mid;
		longint num;
		longint den;
		longint a;
		longint s;
		m = (size_reg == 0) ? 1 : ((size_reg > Knots) ? Knots : int'(size_reg));
		if (t <= knot_xs[0]) begin
			r.interp_value = knot_ys[0];
			r.knot_index = '0;
		end else if (t >= knot_xs[m-1]) begin
			r.interp_value = knot_ys[m-1];
			r.knot_index = SizeW'(m);
		end else begin
			lo = -1;
			hi = m;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (knot_xs[mid] > t) hi = mid;
				else lo = mid;
			end
			if (hi >= m) begin
				r.interp_value = knot_ys[m-1];
				r.knot_index = SizeW'(m);
			end else begin
				num = longint'(t) - longint'(knot_xs[hi-1]);
				den = longint'(knot_xs[hi]) - longint'(knot_xs[hi-1]);
				if (den <= 0 || num >= den) a = 0;
				else a = (num <<< Frac) / den;
				s = a * longint'(knot_ys[hi]) + ((64'sd1 <<< Frac) - a) * longint'(knot_ys[hi-1]);
				s = s >>> Frac;
				r.interp_value = s[31:0];
				r.knot_index = SizeW'(hi);
			end
		end
		return r;
	endfunction

	function automatic row_t ld(logic [IdxW-1:0] slot, logic signed [31:0] x,
			logic signed [31:0] y);
		row_t r;
		r = '0;
		r.req.action = ActLoad;
		r.req.entry_index = slot;
		r.req.knot_x = x;
		r.req.knot_y = y;
		return r;
	endfunction

	function automatic row_t qy(logic signed [31:0] t);
		row_t r;
		r = '0;
		r.req.action = ActQuery;
		r.req.query_t = t;
		return r;
	endfunction

	function automatic row_t qc(logic signed [31:0] t, logic signed [31:0] v,
			logic [SizeW-1:0] idx);
		row_t r;
		r = qy(t);
		r.typed = 1'b1;
		r.exp.interp_value = v;
		r.exp.knot_index = idx;
		return r;
	endfunction

	function automatic row_t cf(logic [SizeW-1:0] v);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.size_val = v;
		return r;
	endfunction

	task automatic pace();
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	task automatic send(req_t r, logic typed, rsp_t e);
		logic ok;
		start <= 1'b1;
		request <= r;
		forever begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
			if (ok) break;
		end
		if (r.action == ActLoad) begin
			knot_xs[r.entry_index] = r.knot_x;
			knot_ys[r.entry_index] = r.knot_y;
		end else begin
			pending_rsp.push_back(typed ? e : interp_predict(r.query_t));
		end
	endtask

	task automatic write_size(logic [SizeW-1:0] v);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
	endtask

	task automatic load_table(int m, int mode);
		longint span;
		longint base;
		longint x;
		req_t   r;
		r = '0;
		r.action = ActLoad;
		span = 64'sh1_0000_0000 / m;
		base = -64'sh8000_0000 + longint'($urandom) % (64'sh1_0000_0000 - m * 4096);
		x = base;
		for (int k = 0; k < m; k++) begin
			case (mode)
				0: x = -64'sh8000_0000 + k * span + longint'($urandom) % (span / 2 + 1);
				1: x = x + $urandom_range(0, 4096);
				default: x = longint'($signed($urandom));
			endcase
			if (mode == 0 && k == m - 1 && m > 1 && $urandom_range(0, 1)) x = Smax;
			r.entry_index = IdxW'(k);
			r.knot_x = x[31:0];
			r.knot_y = $urandom;
			pace();
			send(r, 1'b0, '0);
		end
	endtask

	task automatic query_phase(int m, int n);
		req_t r;
		int   k;
		longint lo;
		longint gap;
		for (int q = 0; q < n; q++) begin
			r = '0;
			k = $urandom_range(0, m - 1);
			if ($urandom_range(0, 9) == 0) begin
				r.action = ActLoad;
				r.entry_index = IdxW'($urandom);
				r.knot_x = $urandom;
				r.knot_y = $urandom;
			end else begin
				r.action = ActQuery;
				r.entry_index = IdxW'($urandom);
				r.knot_x = $urandom;
				r.knot_y = $urandom;
				case ($urandom_range(0, 4))
					0: r.query_t = $urandom;
					1: r.query_t = knot_xs[k];
					2: r.query_t = knot_xs[k] + ($urandom_range(0, 1) ? 1 : -1);
					3: r.query_t = $urandom_range(0, 1) ? Smax : Smin;
					default: begin
						lo = knot_xs[k];
						gap = (k + 1 < m) ? longint'(knot_xs[k+1]) - lo : 64'sd65536;
						if (gap < 0) gap = 64'sd1;
						r.query_t = 32'(lo + longint'($urandom) % (gap + 1));
					end
				endcase
			end
			pace();
			send(r, 1'b0, '0);
		end
	endtask

	always @(negedge clk) begin
		rsp_t e;
		if (arst_n && result_valid) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with none expected: actual value %0d index %0d",
					$time, result.interp_value, result.knot_index);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (result.interp_value !== e.interp_value) begin
					$display("%0t: interp_value expected %0d actual %0d",
						$time, e.interp_value, result.interp_value);
					errors++;
				end
				if (result.knot_index !== e.knot_index) begin
					$display("%0t: knot_index expected %0d actual %0d",
						$time, e.knot_index, result.knot_index);
					errors++;
				end
			end
		end
	end

	initial begin
		int sizes [13];
		int m;
		errors = 0;
		burst_left = 0;
		size_reg = 1;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		foreach (knot_xs[i]) begin
			knot_xs[i] = '0;
			knot_ys[i] = '0;
		end
		dir_rows = '{
			ld(0, 32'sh0, Three),
			qc(Smin, Three, 0),
			qc(32'sh0, Three, 0),
			qc(Smax, Three, 1),
			ld(1, Smax, Smin),
			ld(255, Smin, Smax),
			cf(2),
			qy(32'sh4000_0000),
			qy(32'sh7FFF_FFFE),
			qy(32'sh1),
			qc(Smax, Smin, 2),
			ld(2, 32'shFFFB_0000, 32'sh0007_0000),
			cf(3),
			qc(32'sh0000_8000, 32'sh0007_0000, 3),
			qc(-32'sh1, Three, 0),
			cf(0),
			qc(32'sh5, Three, 1)
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_size(dir_rows[i].size_val);
			end else begin
				pace();
				send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);
			end
		end

		sizes = '{256, 511, 1, 2, 0, 3, 8, 255, 33, 4, 16, 7, 128};
		foreach (sizes[p]) begin
			m = (sizes[p] == 0) ? 1 : ((sizes[p] > Knots) ? Knots : sizes[p]);
			write_size(SizeW'(sizes[p]));
			load_table(m, (p == 0) ? 0 : $urandom_range(0, 3));
			query_phase(m, 25);
		end

		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
